>>> rtl/dcpg_pkg.sv
// Shared types, constants and helpers for the DMA copy-program generator.
// Depends on nothing; every other file uses it.
package dcpg_pkg;

    localparam int PROGRAM_BYTES = 128;
    localparam int BURST_BEATS   = 16;
    localparam int MAX_RESULTS   = 26;

    localparam int ADDR_W   = 32;
    localparam int BYTES_W  = 16;
    localparam int CHAN_W   = 3;
    localparam int INSN_W   = 48;
    localparam int LEN_W    = 3;
    localparam int STS_W    = 2;

    localparam int WORDS_W  = BYTES_W - 2;
    localparam int SNG_W    = $clog2(BURST_BEATS + 1);
    localparam int RECIP_SH = WORDS_W + 5;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int RECIP    = ((2 ** RECIP_SH) + BURST_BEATS - 1) / BURST_BEATS;
    localparam int PROD_W   = WORDS_W + RECIP_W;
    localparam int LOOP_MAX = 256;
    localparam int LOOP_W   = WORDS_W - 8 + 1;
    localparam int SUM_W    = 16;

    localparam logic [7:0] OP_MOV   = 8'hbc;
    localparam logic [7:0] OP_LP    = 8'h20;
    localparam logic [7:0] OP_LPEND = 8'h28;
    localparam logic [7:0] OP_LD    = 8'h04;
    localparam logic [7:0] OP_ST    = 8'h08;
    localparam logic [7:0] OP_SEV   = 8'h34;
    localparam logic [7:0] OP_END   = 8'h00;

    localparam logic [7:0] MOV_SAR  = 8'd0;
    localparam logic [7:0] MOV_CCR  = 8'd1;
    localparam logic [7:0] MOV_DAR  = 8'd2;

    localparam logic [STS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STS_W-1:0] ST_ALIGN = 2'd1;
    localparam logic [STS_W-1:0] ST_LEN   = 2'd2;
    localparam logic [STS_W-1:0] ST_LONG  = 2'd3;

    typedef logic [3:0] ins_sel_t;

    localparam ins_sel_t I_CCR   = 4'd0;
    localparam ins_sel_t I_SAR   = 4'd1;
    localparam ins_sel_t I_DAR   = 4'd2;
    localparam ins_sel_t I_LP    = 4'd3;
    localparam ins_sel_t I_LD    = 4'd4;
    localparam ins_sel_t I_ST    = 4'd5;
    localparam ins_sel_t I_LPEND = 4'd6;
    localparam ins_sel_t I_CCR1  = 4'd7;
    localparam ins_sel_t I_SLP   = 4'd8;
    localparam ins_sel_t I_SEV   = 4'd9;
    localparam ins_sel_t I_END   = 4'd10;
    localparam ins_sel_t I_ERR   = 4'd11;

    typedef struct packed {
        logic     load;
        logic     mul;
        logic     div;
        logic     size;
        logic     emit;
        ins_sel_t sel;
        logic     dec;
    } dcpg_cmd_t;

    typedef struct packed {
        logic [STS_W-1:0] code;
        logic             rem_zero;
        logic             rem_last;
        logic             single_zero;
    } dcpg_sts_t;

    function automatic logic [31:0] make_ccr(input logic [4:0] beats);
        logic [3:0]  len;
        logic [31:0] c;
        len = 4'(beats - 5'd1);
        c = 32'd0;
        c[0]     = 1'b1;
        c[14]    = 1'b1;
        c[8]     = 1'b1;
        c[22]    = 1'b1;
        c[7:4]   = len;
        c[21:18] = len;
        c[2:1]   = 2'd2;
        c[16:15] = 2'd2;
        return c;
    endfunction

    function automatic logic [INSN_W-1:0] mov_word(input logic [7:0] rsel,
                                                   input logic [31:0] val);
        return {val, rsel, OP_MOV};
    endfunction

    localparam logic [31:0] CCR_BURST  = make_ccr(5'(BURST_BEATS));
    localparam logic [31:0] CCR_SINGLE = make_ccr(5'd1);

endpackage

>>> rtl/dcpg_if.sv
// Valid/ready channel interfaces for requests and emitted instructions.
// Depends on dcpg_pkg.
interface dcpg_req_if;
    logic                         valid;
    logic                         ready;
    logic [dcpg_pkg::ADDR_W-1:0]  source_address;
    logic [dcpg_pkg::ADDR_W-1:0]  dest_address;
    logic [dcpg_pkg::BYTES_W-1:0] byte_count;
    logic [dcpg_pkg::CHAN_W-1:0]  channel_number;

    modport source (output valid, source_address, dest_address, byte_count,
                    channel_number, input ready);
    modport sink   (input valid, source_address, dest_address, byte_count,
                    channel_number, output ready);
endinterface

interface dcpg_ins_if;
    logic                        valid;
    logic                        ready;
    logic [dcpg_pkg::INSN_W-1:0] instruction_word;
    logic [dcpg_pkg::LEN_W-1:0]  instruction_length;
    logic [dcpg_pkg::STS_W-1:0]  status_code;
    logic                        last_of_run;

    modport source (output valid, instruction_word, instruction_length, status_code,
                    last_of_run, input ready);
    modport sink   (input valid, instruction_word, instruction_length, status_code,
                    last_of_run, output ready);
endinterface

>>> rtl/dma_copy_program_generator.sv
// Top level of the DMA copy-program generator: sequencer plus datapath.
// Depends on dcpg_pkg, dcpg_if, dcpg_ctrl and dcpg_dpath.
//
// req carries one copy request (source, destination, byte count, channel).
// ins carries the generated program, one instruction per item, first byte in
// bits 7:0; last_of_run marks END, or the single error item (length 0 and a
// nonzero status code) for a misaligned address, a bad length or a program
// that would not fit the buffer or the instruction limit.
// A request is taken only when the block is idle. After acceptance, the
// sizing steps (reciprocal multiply, quotient, remainder/loop count) and the
// check step pass before the first item is registered for output.
// Then one item leaves per cycle while ins is ready; the longest program is
// 26 instructions. A stall on ins holds the current item in the output
// register and freezes the sequencer in its emit states. Reset empties the
// output register and returns to idle.
module dma_copy_program_generator
(
    input  logic        clk,
    input  logic        rst_n,
    dcpg_req_if.sink    req,
    dcpg_ins_if.source  ins
);
    import dcpg_pkg::*;

    dcpg_cmd_t cmd;
    dcpg_sts_t sts;

    dcpg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .ins_ready (ins.ready),
        .ins_valid (ins.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    dcpg_dpath u_dpath
    (
        .clk                (clk),
        .source_address     (req.source_address),
        .dest_address       (req.dest_address),
        .byte_count         (req.byte_count),
        .channel_number     (req.channel_number),
        .cmd                (cmd),
        .sts                (sts),
        .instruction_word   (ins.instruction_word),
        .instruction_length (ins.instruction_length),
        .status_code        (ins.status_code),
        .last_of_run        (ins.last_of_run)
    );

endmodule

>>> rtl/dcpg_ctrl.sv
// Sequencer for the copy-program generator: sizing steps, then one instruction
// per step. Depends on dcpg_pkg.
module dcpg_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                ins_ready,
    output logic                ins_valid,
    input  dcpg_pkg::dcpg_sts_t sts,
    output dcpg_pkg::dcpg_cmd_t cmd
);
    import dcpg_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MUL  = 5'd1;
    localparam logic [4:0] S_DIV  = 5'd2;
    localparam logic [4:0] S_SIZE = 5'd3;
    localparam logic [4:0] S_CHK  = 5'd4;
    localparam logic [4:0] E_CCR  = 5'd5;
    localparam logic [4:0] E_SAR  = 5'd6;
    localparam logic [4:0] E_DAR  = 5'd7;
    localparam logic [4:0] E_LP   = 5'd8;
    localparam logic [4:0] E_LD   = 5'd9;
    localparam logic [4:0] E_ST   = 5'd10;
    localparam logic [4:0] E_LE   = 5'd11;
    localparam logic [4:0] E_CCR1 = 5'd12;
    localparam logic [4:0] E_SLP  = 5'd13;
    localparam logic [4:0] E_SLD  = 5'd14;
    localparam logic [4:0] E_SST  = 5'd15;
    localparam logic [4:0] E_SLE  = 5'd16;
    localparam logic [4:0] E_SEV  = 5'd17;
    localparam logic [4:0] E_END  = 5'd18;
    localparam logic [4:0] E_ERR  = 5'd19;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       ovalid_reg;
    logic       ovalid_next;
    logic       slot_free;
    logic [4:0] after_body;

    assign slot_free = !ovalid_reg || ins_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign ins_valid = ovalid_reg;

    // where to go once the burst loops are done
    assign after_body = sts.single_zero ? E_SEV : E_CCR1;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = S_SIZE;
            end
            S_SIZE:
            begin
                cmd.size   = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = (sts.code == ST_OK) ? E_CCR : E_ERR;
            end
            default:
            begin
                if (slot_free)
                begin
                    cmd.emit = 1'b1;
                    unique case (state_reg)
                        E_CCR:
                        begin
                            cmd.sel    = I_CCR;
                            state_next = E_SAR;
                        end
                        E_SAR:
                        begin
                            cmd.sel    = I_SAR;
                            state_next = E_DAR;
                        end
                        E_DAR:
                        begin
                            cmd.sel    = I_DAR;
                            state_next = sts.rem_zero ? after_body : E_LP;
                        end
                        E_LP:
                        begin
                            cmd.sel    = I_LP;
                            state_next = E_LD;
                        end
                        E_LD:
                        begin
                            cmd.sel    = I_LD;
                            state_next = E_ST;
                        end
                        E_ST:
                        begin
                            cmd.sel    = I_ST;
                            state_next = E_LE;
                        end
                        E_LE:
                        begin
                            cmd.sel    = I_LPEND;
                            cmd.dec    = 1'b1;
                            state_next = sts.rem_last ? after_body : E_LP;
                        end
                        E_CCR1:
                        begin
                            cmd.sel    = I_CCR1;
                            state_next = E_SLP;
                        end
                        E_SLP:
                        begin
                            cmd.sel    = I_SLP;
                            state_next = E_SLD;
                        end
                        E_SLD:
                        begin
                            cmd.sel    = I_LD;
                            state_next = E_SST;
                        end
                        E_SST:
                        begin
                            cmd.sel    = I_ST;
                            state_next = E_SLE;
                        end
                        E_SLE:
                        begin
                            cmd.sel    = I_LPEND;
                            state_next = E_SEV;
                        end
                        E_SEV:
                        begin
                            cmd.sel    = I_SEV;
                            state_next = E_END;
                        end
                        E_END:
                        begin
                            cmd.sel    = I_END;
                            state_next = S_IDLE;
                        end
                        E_ERR:
                        begin
                            cmd.sel    = I_ERR;
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            cmd.emit   = 1'b0;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    assign ovalid_next = cmd.emit ? 1'b1 : (ins_ready ? 1'b0 : ovalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

>>> rtl/dcpg_dpath.sv
// Datapath: request registers, burst/remainder split, size check and the
// instruction output register. Depends on dcpg_pkg.
module dcpg_dpath
(
    input  logic                          clk,
    input  logic [dcpg_pkg::ADDR_W-1:0]   source_address,
    input  logic [dcpg_pkg::ADDR_W-1:0]   dest_address,
    input  logic [dcpg_pkg::BYTES_W-1:0]  byte_count,
    input  logic [dcpg_pkg::CHAN_W-1:0]   channel_number,
    input  dcpg_pkg::dcpg_cmd_t           cmd,
    output dcpg_pkg::dcpg_sts_t           sts,
    output logic [dcpg_pkg::INSN_W-1:0]   instruction_word,
    output logic [dcpg_pkg::LEN_W-1:0]    instruction_length,
    output logic [dcpg_pkg::STS_W-1:0]    status_code,
    output logic                          last_of_run
);
    import dcpg_pkg::*;

    logic [ADDR_W-1:0]  src_reg;
    logic [ADDR_W-1:0]  dst_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [CHAN_W-1:0]  chan_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [WORDS_W-1:0] rem_reg;
    logic [SNG_W-1:0]   single_reg;
    logic [LOOP_W-1:0]  loops_reg;

    logic [INSN_W-1:0]  word_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [STS_W-1:0]   code_reg;
    logic               last_reg;

    logic [WORDS_W-1:0] words;
    logic [WORDS_W-1:0] burst_words;
    logic [WORDS_W:0]   rem_round;
    logic [SUM_W-1:0]   nbytes;
    logic [SUM_W-1:0]   nres;
    logic [STS_W-1:0]   chk_code;
    logic [7:0]         lp_cnt;
    logic [7:0]         slp_cnt;
    logic [INSN_W-1:0]  word_next;
    logic [LEN_W-1:0]   len_next;
    logic [STS_W-1:0]   code_next;
    logic               last_next;

    assign words       = bytes_reg[BYTES_W-1:2];
    assign burst_words = WORDS_W'(rem_reg * WORDS_W'(BURST_BEATS));
    assign rem_round   = {1'b0, rem_reg} + (WORDS_W+1)'(LOOP_MAX - 1);

    // program size in bytes and instructions
    assign nbytes = SUM_W'(21) + SUM_W'(loops_reg) * SUM_W'(6)
                  + ((single_reg != '0) ? SUM_W'(12) : SUM_W'(0));
    assign nres   = SUM_W'(5) + SUM_W'(loops_reg) * SUM_W'(4)
                  + ((single_reg != '0) ? SUM_W'(5) : SUM_W'(0));

    always_comb
    begin
        if (src_reg[1:0] != 2'd0 || dst_reg[1:0] != 2'd0)
            chk_code = ST_ALIGN;
        else if (bytes_reg[1:0] != 2'd0)
            chk_code = ST_LEN;
        else if (nbytes > SUM_W'(PROGRAM_BYTES) || nres > SUM_W'(MAX_RESULTS))
            chk_code = ST_LONG;
        else
            chk_code = ST_OK;
    end

    assign sts.code        = chk_code;
    assign sts.rem_zero    = (rem_reg == '0);
    assign sts.rem_last    = (rem_reg <= WORDS_W'(LOOP_MAX));
    assign sts.single_zero = (single_reg == '0);

    assign lp_cnt  = (rem_reg >= WORDS_W'(LOOP_MAX)) ? 8'hff : 8'(rem_reg[7:0] - 8'd1);
    assign slp_cnt = 8'(8'(single_reg) - 8'd1);

    always_comb
    begin
        word_next = '0;
        len_next  = 3'd2;
        code_next = ST_OK;
        last_next = 1'b0;
        unique case (cmd.sel)
            I_CCR:
            begin
                word_next = mov_word(MOV_CCR, CCR_BURST);
                len_next  = 3'd6;
            end
            I_SAR:
            begin
                word_next = mov_word(MOV_SAR, src_reg);
                len_next  = 3'd6;
            end
            I_DAR:
            begin
                word_next = mov_word(MOV_DAR, dst_reg);
                len_next  = 3'd6;
            end
            I_CCR1:
            begin
                word_next = mov_word(MOV_CCR, CCR_SINGLE);
                len_next  = 3'd6;
            end
            I_LP:    word_next = INSN_W'({lp_cnt, OP_LP});
            I_SLP:   word_next = INSN_W'({slp_cnt, OP_LP});
            I_LPEND: word_next = INSN_W'({8'd2, OP_LPEND | 8'h10});
            I_LD:
            begin
                word_next = INSN_W'(OP_LD);
                len_next  = 3'd1;
            end
            I_ST:
            begin
                word_next = INSN_W'(OP_ST);
                len_next  = 3'd1;
            end
            I_SEV:   word_next = INSN_W'({chan_reg, 3'd0, OP_SEV});
            I_END:
            begin
                word_next = INSN_W'(OP_END);
                len_next  = 3'd1;
                last_next = 1'b1;
            end
            I_ERR:
            begin
                len_next  = 3'd0;
                code_next = chk_code;
                last_next = 1'b1;
            end
            default:
            begin
                word_next = '0;
                len_next  = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            src_reg   <= source_address;
            dst_reg   <= dest_address;
            bytes_reg <= byte_count;
            chan_reg  <= channel_number;
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(words) * PROD_W'(RECIP);
        // quotient by reciprocal is exact for the whole word range
        if (cmd.div)
            rem_reg <= prod_reg[RECIP_SH +: WORDS_W];
        if (cmd.size)
        begin
            single_reg <= SNG_W'(words - burst_words);
            loops_reg  <= rem_round[WORDS_W:8];
        end
        if (cmd.dec)
            rem_reg <= sts.rem_last ? '0 : WORDS_W'(rem_reg - WORDS_W'(LOOP_MAX));
        if (cmd.emit)
        begin
            word_reg <= word_next;
            len_reg  <= len_next;
            code_reg <= code_next;
            last_reg <= last_next;
        end
    end

    assign instruction_word   = word_reg;
    assign instruction_length = len_reg;
    assign status_code        = code_reg;
    assign last_of_run        = last_reg;

endmodule

>>> rtl/dcpg_checker.sv
// Port-level checks for the copy-program generator, bound to the top level.
// Depends on dcpg_pkg.
module dcpg_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        ins_valid,
    input logic                        ins_ready,
    input logic [dcpg_pkg::INSN_W-1:0] ins_word,
    input logic [dcpg_pkg::LEN_W-1:0]  ins_length,
    input logic [dcpg_pkg::STS_W-1:0]  ins_status,
    input logic                        ins_last
);
    import dcpg_pkg::*;

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        ins_valid && ins_status != ST_OK |-> ins_last && ins_length == 3'd0)
        else $error("error item not a lone zero-length last item");

    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        ins_valid && ins_status == ST_OK |-> ins_length != 3'd0)
        else $error("instruction with zero length");

    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        ins_valid && !ins_last |-> !req_ready)
        else $error("request taken mid-run");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready after accept");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ins_valid && !ins_ready |=> ins_valid && $stable(ins_word))
        else $error("stalled item changed");

endmodule

bind dma_copy_program_generator dcpg_checker u_dcpg_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .ins_valid  (ins.valid),
    .ins_ready  (ins.ready),
    .ins_word   (ins.instruction_word),
    .ins_length (ins.instruction_length),
    .ins_status (ins.status_code),
    .ins_last   (ins.last_of_run)
);
